@@ sv/qalsr_pkg.sv @@
package qalsr_pkg;

    // Sizing defaults and fixed field widths
    localparam int DEF_MAX_SLOTS = 8;
    localparam int ACTIVE_RESET  = 8;
    localparam int SITE_W        = 8;
    localparam int QUOTA_W       = 4;
    localparam int POT_W         = 32;
    localparam int TAG_W         = 16;
    localparam int OUT_IDX_W     = 3;
    localparam int ACT_CFG_W     = 4;
    localparam int CMP_W         = 8;
    localparam int S_DATA_W      = 64;
    localparam int M_DATA_W      = 8;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // tdata field offsets on the input channel
    localparam int SITE_LSB  = 0;
    localparam int QUOTA_LSB = SITE_LSB + SITE_W;
    localparam int POT_LSB   = QUOTA_LSB + QUOTA_W;
    localparam int TAG_LSB   = POT_LSB + POT_W;

    // Opcodes carried on s_tuser
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register index (paddr word bit)
    localparam logic REG_ACTIVE_SLOTS = 1'b0;

    // One slot as stored in the table memory
    typedef struct packed {
        logic [SITE_W-1:0]        site;
        logic signed [POT_W-1:0]  pot;
        logic [QUOTA_W-1:0]       quota;
        logic [TAG_W-1:0]         tag;
    } slot_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CNT  = 4'b0010,
        S_SEL  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

@@ sv/quota_aware_lowest_slot_replace.sv @@
// Quota-aware lowest-slot replacement table.
//
// Input beats (s_*) carry an opcode on s_tuser: offer a candidate or clear all
// slots. An offer scans the active slots twice through the slot memory: first
// to count the slots already held by the offering site, then to find the
// lowest-potential eligible slot. If that potential is below the offer, the
// slot is overwritten. One result beat (m_*) follows every input beat.
//
// An offer reads the slot memory once per active slot in each pass. A clear, or
// an offer with no active slot, goes straight to the result. One item is in
// work at a time; the next beat is taken once the result is in the output
// register, even while the receiver stalls it.
//
// The APB register active_slots (byte address 0) clears the slots at or
// beyond its new value. Reset empties every slot at once through per-slot
// valid bits, sets active_slots to 8 (MAX_SLOTS if smaller) and needs no clearing pass.
module quota_aware_lowest_slot_replace #(
    parameter int MAX_SLOTS = qalsr_pkg::DEF_MAX_SLOTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // site_id[7:0], site_quota[11:8], offered_potential[43:12], file_tag[59:44]
    input  logic [qalsr_pkg::S_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // slot_index[2:0]
    output logic [qalsr_pkg::M_DATA_W-1:0]      m_tdata,
    // accepted
    output logic                                m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qalsr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [qalsr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [qalsr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import qalsr_pkg::*;

    localparam int IW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW      = $clog2(MAX_SLOTS + 1);
    localparam int ACT_RST = (ACTIVE_RESET > MAX_SLOTS) ? MAX_SLOTS : ACTIVE_RESET;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            active_reg, active_next;
    logic [MAX_SLOTS-1:0]     valid_reg, valid_next;
    logic [CW-1:0]            iss_reg, iss_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     own_reg, own_next;
    logic                     found_reg, found_next;
    logic signed [POT_W-1:0]  low_reg, low_next;
    logic [IW-1:0]            best_reg, best_next;
    logic                     res_acc_reg, res_acc_next;
    logic [IW-1:0]            res_idx_reg, res_idx_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic                     m_acc_reg;
    logic [OUT_IDX_W-1:0]     m_idx_reg;

    logic [SITE_W-1:0]        in_site_reg;
    logic [QUOTA_W-1:0]       in_quota_reg;
    logic signed [POT_W-1:0]  in_pot_reg;
    logic [TAG_W-1:0]         in_tag_reg;

    // Slot memory and its read pipeline
    slot_t                    mem [MAX_SLOTS];
    slot_t                    rd_data_reg;
    logic                     rd_vld_reg;
    logic [IW-1:0]            rd_idx_reg;
    logic                     rd_en;
    logic                     mem_we;
    slot_t                    mem_wd;

    logic                     s_accept;
    logic                     cfg_wr;
    logic [CMP_W-1:0]         cfg_n;
    logic                     last_rd;
    logic [SITE_W-1:0]        eff_site;
    logic signed [POT_W-1:0]  eff_pot;
    logic                     site_hit;
    logic                     elig;
    logic                     take;
    logic                     cand_found;
    logic signed [POT_W-1:0]  cand_low;
    logic [IW-1:0]            cand_best;
    logic [CW-1:0]            cnt_sum;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_acc_reg;
    assign m_tdata  = M_DATA_W'(m_idx_reg);

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_n  = (CMP_W'(pwdata[ACT_CFG_W-1:0]) > CMP_W'(MAX_SLOTS)) ?
                    CMP_W'(MAX_SLOTS) : CMP_W'(pwdata[ACT_CFG_W-1:0]);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_ACTIVE_SLOTS) ?
                    APB_DATA_W'(active_reg) : '0;

    // Slot read issue and what the returning entry means
    assign rd_en    = ((state_reg == S_CNT) || (state_reg == S_SEL)) && (iss_reg < active_reg);
    assign last_rd  = rd_vld_reg && ((CW'(rd_idx_reg) + CW'(1)) == active_reg);
    assign eff_site = valid_reg[rd_idx_reg] ? rd_data_reg.site : '0;
    assign eff_pot  = valid_reg[rd_idx_reg] ? rd_data_reg.pot : '0;
    assign site_hit = (eff_site == in_site_reg);
    assign cnt_sum  = cnt_reg + CW'(site_hit);

    // Running minimum over eligible slots, first index wins a tie
    assign elig       = !own_reg || site_hit;
    assign take       = elig && (!found_reg || (eff_pot < low_reg));
    assign cand_found = found_reg || elig;
    assign cand_low   = take ? eff_pot : low_reg;
    assign cand_best  = take ? rd_idx_reg : best_reg;

    assign mem_we = (state_reg == S_SEL) && last_rd && cand_found && (cand_low < in_pot_reg);
    assign mem_wd = '{site: in_site_reg, pot: in_pot_reg, quota: in_quota_reg, tag: in_tag_reg};

    // Control next state
    always_comb begin
        state_next    = state_reg;
        active_next   = active_reg;
        valid_next    = valid_reg;
        iss_next      = iss_reg;
        cnt_next      = cnt_reg;
        own_next      = own_reg;
        found_next    = found_reg;
        low_next      = low_reg;
        best_next     = best_reg;
        res_acc_next  = res_acc_reg;
        res_idx_next  = res_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (rd_en) begin
            iss_next = iss_reg + CW'(1);
        end

        // count write drops the slots at or above the new count
        if (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_ACTIVE_SLOTS)) begin
            active_next = CW'(cfg_n);
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (CMP_W'(i) >= cfg_n) valid_next[i] = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    iss_next     = '0;
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    res_acc_next = 1'b0;
                    res_idx_next = '0;
                    if (s_tuser == OP_CLEAR) begin
                        valid_next = '0;
                        state_next = S_DONE;
                    end else if (active_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_CNT;
                    end
                end
            end
            S_CNT: begin
                if (rd_vld_reg) cnt_next = cnt_sum;
                if (last_rd) begin
                    own_next   = (CMP_W'(cnt_sum) == CMP_W'(in_quota_reg));
                    iss_next   = '0;
                    state_next = S_SEL;
                end
            end
            S_SEL: begin
                if (rd_vld_reg) begin
                    found_next = cand_found;
                    low_next   = cand_low;
                    best_next  = cand_best;
                end
                if (last_rd) begin
                    res_acc_next = mem_we;
                    res_idx_next = mem_we ? cand_best : '0;
                    if (mem_we) valid_next[cand_best] = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            active_reg   <= CW'(ACT_RST);
            valid_reg    <= '0;
            iss_reg      <= '0;
            cnt_reg      <= '0;
            own_reg      <= 1'b0;
            found_reg    <= 1'b0;
            res_acc_reg  <= 1'b0;
            res_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            valid_reg    <= valid_next;
            iss_reg      <= iss_next;
            cnt_reg      <= cnt_next;
            own_reg      <= own_next;
            found_reg    <= found_next;
            res_acc_reg  <= res_acc_next;
            res_idx_reg  <= res_idx_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_vld_reg   <= rd_en;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        low_reg    <= low_next;
        best_reg   <= best_next;
        rd_idx_reg <= iss_reg[IW-1:0];
        if (s_accept) begin
            in_site_reg  <= s_tdata[SITE_LSB +: SITE_W];
            in_quota_reg <= s_tdata[QUOTA_LSB +: QUOTA_W];
            in_pot_reg   <= s_tdata[POT_LSB +: POT_W];
            in_tag_reg   <= s_tdata[TAG_LSB +: TAG_W];
        end
        if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready)) begin
            m_acc_reg <= res_acc_reg;
            m_idx_reg <= OUT_IDX_W'(res_idx_reg);
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[cand_best] <= mem_wd;
        if (rd_en) rd_data_reg <= mem[iss_reg[IW-1:0]];
    end

    // Checks
    a_we_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_SEL) && last_rd)
        else $error("slot write outside the end of the select pass");

    a_we_active: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (CW'(cand_best) < active_reg))
        else $error("slot write beyond the active slots");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEL) |-> (cnt_reg <= active_reg))
        else $error("site count exceeds active slots");

    a_rd_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> ((state_reg == S_CNT) || (state_reg == S_SEL)))
        else $error("read data returned outside a scan pass");

    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != S_IDLE))
        else $error("accepted beat left the sequencer idle");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import qalsr_pkg::*;

    localparam int  N_SLOTS   = DEF_MAX_SLOTS;
    localparam logic REG_SPARE = 1'b1;   // unmapped word, writes are dropped

    // One input beat as the sender sees it
    typedef struct {
        logic                    op;
        logic [SITE_W-1:0]       site;
        logic [QUOTA_W-1:0]      quota;
        logic signed [POT_W-1:0] pot;
        logic [TAG_W-1:0]        tag;
    } bid_t;

    // One result beat
    typedef struct packed {
        logic                 accepted;
        logic [OUT_IDX_W-1:0] index;
    } verdict_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tuser  = OP_OFFER;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    quota_aware_lowest_slot_replace #(.MAX_SLOTS(N_SLOTS)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock and reset
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Shadow copy of the slot table
    logic [SITE_W-1:0]       held_site  [N_SLOTS];
    logic signed [POT_W-1:0] held_pot   [N_SLOTS];
    logic [QUOTA_W-1:0]      held_quota [N_SLOTS];
    logic [TAG_W-1:0]        held_tag   [N_SLOTS];
    int                      live_slots = ACTIVE_RESET;

    verdict_t verdicts_due[$];
    int       err_count   = 0;
    int       send_idle   = 0;    // percent of cycles the sender holds back
    int       recv_stall  = 0;    // percent of cycles the receiver stalls
    int       hold_req    = 0;    // long receiver hold-off, in cycles
    int       hold_left   = 0;

    initial begin
        for (int i = 0; i < N_SLOTS; i++) begin
            held_site[i]  = '0;
            held_pot[i]   = '0;
            held_quota[i] = '0;
            held_tag[i]   = '0;
        end
    end

    function automatic void empty_slot(int i);
        held_site[i]  = '0;
        held_pot[i]   = '0;
        held_quota[i] = '0;
        held_tag[i]   = '0;
    endfunction

    // Count register write: saturate to the table size, drop slots at or above it
    function automatic void set_live_slots(logic [ACT_CFG_W-1:0] val);
        int n;
        n = int'(val);
        if (n > N_SLOTS) n = N_SLOTS;
        live_slots = n;
        for (int i = n; i < N_SLOTS; i++) empty_slot(i);
    endfunction

    // Quota check, lowest-potential pick and replacement for one beat
    function automatic verdict_t place_bid(bid_t b);
        verdict_t                v;
        int                      held_by_site;
        int                      pick;
        bit                      own_only;
        bit                      found;
        logic signed [POT_W-1:0] lowest;
        v            = '0;
        held_by_site = 0;
        pick         = 0;
        found        = 1'b0;
        lowest       = '0;
        if (b.op == OP_CLEAR) begin
            for (int i = 0; i < N_SLOTS; i++) empty_slot(i);
            return v;
        end
        for (int i = 0; i < live_slots; i++)
            if (held_site[i] == b.site) held_by_site++;
        own_only = (held_by_site == b.quota);
        for (int i = 0; i < live_slots; i++) begin
            if (own_only && held_site[i] != b.site) continue;
            if (!found || held_pot[i] < lowest) begin
                lowest = held_pot[i];
                pick   = i;
                found  = 1'b1;
            end
        end
        if (found && lowest < b.pot) begin
            held_site[pick]  = b.site;
            held_pot[pick]   = b.pot;
            held_quota[pick] = b.quota;
            held_tag[pick]   = b.tag;
            v.accepted = 1'b1;
            v.index    = pick[OUT_IDX_W-1:0];
        end
        return v;
    endfunction

    function automatic bid_t offer(logic [SITE_W-1:0] site, logic [QUOTA_W-1:0] quota,
                                   logic signed [POT_W-1:0] pot, logic [TAG_W-1:0] tag);
        bid_t b;
        b.op    = OP_OFFER;
        b.site  = site;
        b.quota = quota;
        b.pot   = pot;
        b.tag   = tag;
        return b;
    endfunction

    // Random beat: few sites and small quotas so the quota rule bites often
    function automatic bid_t random_bid();
        bid_t b;
        int   r;
        b.op = ($urandom_range(0, 99) < 4) ? OP_CLEAR : OP_OFFER;
        r = $urandom_range(0, 99);
        if (r < 70)      b.site = SITE_W'($urandom_range(1, 4));
        else if (r < 80) b.site = '0;
        else             b.site = SITE_W'($urandom_range(0, 255));
        b.quota = ($urandom_range(0, 99) < 70) ? QUOTA_W'($urandom_range(1, 3))
                                               : QUOTA_W'($urandom_range(0, 8));
        r = $urandom_range(0, 99);
        if (r < 60)      b.pot = $signed($urandom_range(0, 40)) - 20;
        else if (r < 75) b.pot = $urandom;
        else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       b.pot = 32'sh8000_0000;
                1:       b.pot = 32'sh7FFF_FFFF;
                2:       b.pot = '0;
                default: b.pot = -1;
            endcase
        end else         b.pot = $signed($urandom_range(0, 2000)) - 1000;
        b.tag = TAG_W'($urandom);
        return b;
    endfunction

    function automatic bid_t clear_bid();
        bid_t b;
        b    = random_bid();
        b.op = OP_CLEAR;
        return b;
    endfunction

    // Offer one beat; returns at the edge where it is taken
    task automatic send_bid(bid_t b);
        if ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.op;
        s_tdata  <= {4'b0, b.tag, b.pot, b.quota, b.site};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        verdicts_due.insert(verdicts_due.size(), place_bid(b));
    endtask

    // Wait for every due result, with valid dropped
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write: setup cycle then access cycle; only while idle
    task automatic apb_write(logic idx, logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_ACTIVE_SLOTS) set_live_slots(val[ACT_CFG_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: random stalls, plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Result checker
    always @(posedge aclk) begin : check_result
        verdict_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result beat with none due: accepted %0d index %0d",
                         $time, m_tuser, m_tdata);
                err_count++;
            end else begin
                due = verdicts_due.pop_front();
                if (m_tuser !== due.accepted) begin
                    $display("%0t: accepted expected %0d actual %0d",
                             $time, due.accepted, m_tuser);
                    err_count++;
                end
                if (m_tdata !== M_DATA_W'(due.index)) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, due.index, m_tdata);
                    err_count++;
                end
            end
        end
    end

    // Quota rule, ties, extremes and site zero on a table straight out of reset
    task automatic test_offer_rules();
        send_bid(offer(8'd1, 4'd2, 32'sd5, 16'h0001));
        send_bid(offer(8'd1, 4'd2, 32'sd0, 16'h0002));            // equal is not lower
        send_bid(offer(8'd2, 4'd1, 32'sh8000_0000, 16'h0000));
        send_bid(offer(8'd255, 4'd8, 32'sh7FFF_FFFF, 16'hFFFF));
        send_bid(offer(8'd1, 4'd1, 32'sd6, 16'h00A5));            // at quota: own slot only
        send_bid(offer(8'd1, 4'd1, 32'sd3, 16'h5A00));
        send_bid(offer(8'd7, 4'd0, 32'sd100, 16'h1234));          // quota 0, holds nothing
        send_bid(offer(8'd0, 4'd6, 32'sd1, 16'h8000));            // site zero takes empties
        send_bid(offer(8'd0, 4'd0, -32'sd1, 16'h7FFF));
        send_bid(clear_bid());
        send_bid(offer(8'd3, 4'd3, 32'sd1, 16'h0F0F));
        wait_drain();
    endtask

    // Count register: zero, saturation, shrinking, and the unmapped word
    task automatic test_active_counts();
        apb_write(REG_ACTIVE_SLOTS, 32'd0);
        send_bid(offer(8'd4, 4'd1, 32'sd9, 16'h0001));            // nothing eligible
        wait_drain();
        apb_write(REG_ACTIVE_SLOTS, 32'd15);
        send_bid(offer(8'd4, 4'd1, 32'sd9, 16'h0002));
        send_bid(offer(8'd5, 4'd2, -32'sd4, 16'h0003));
        wait_drain();
        apb_write(REG_ACTIVE_SLOTS, 32'd3);
        send_bid(offer(8'd6, 4'd2, 32'sd10, 16'h0004));
        send_bid(offer(8'd6, 4'd2, 32'sd11, 16'h0005));
        send_bid(offer(8'd6, 4'd2, 32'sd12, 16'h0006));
        send_bid(offer(8'd9, 4'd1, 32'sd13, 16'h0007));
        wait_drain();
        apb_write(REG_SPARE, 32'd1);
        send_bid(offer(8'd9, 4'd1, 32'sd20, 16'h0008));
        wait_drain();
        apb_write(REG_ACTIVE_SLOTS, 32'd1);
        send_bid(offer(8'd9, 4'd1, 32'sd30, 16'h0009));
        send_bid(offer(8'd2, 4'd1, 32'sd31, 16'h000A));
        wait_drain();
        apb_write(REG_ACTIVE_SLOTS, 32'd8);
    endtask

    // One random phase at a given count and idle mix
    task automatic test_random_mix(int n, logic [APB_DATA_W-1:0] count, int idle, int stall);
        wait_drain();
        apb_write(REG_ACTIVE_SLOTS, count);
        send_idle  = idle;
        recv_stall = stall;
        repeat (n) send_bid(random_bid());
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        send_idle  = 0;
        recv_stall = 0;
        hold_req   = 300;
        repeat (12) send_bid(random_bid());
        wait_drain();
    endtask

    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        test_offer_rules();
        test_active_counts();
        test_random_mix(140, 32'd8, 0, 0);
        test_random_mix(110, 32'd3, 72, 0);
        test_random_mix(110, 32'd8, 0, 72);
        test_random_mix(90, 32'd15, 12, 12);
        test_random_mix(20, 32'd0, 12, 12);
        test_random_mix(20, 32'd1, 0, 0);
        test_random_mix(50, 32'd5, 12, 12);
        test_backpressure();
        repeat (40) @(posedge aclk);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hang guard
    initial begin
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
sv/qalsr_pkg.sv
sv/quota_aware_lowest_slot_replace.sv
bench/tb.sv
